// File: src/assert_macros.svh
// Assertion macros shared by the clock unit RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define WTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wtc assertion failed");

// Checked on every edge, reset included.
`define WTC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("wtc assertion failed, reset included");

`endif

// File: src/wtc_pkg.sv
// Package for the weekday time-of-day clock unit: widths, codes, word types.
// No dependencies; used by wtc_apb_regs, wtc_time_core, the top level and the bench.
package wtc_pkg;

  localparam int unsigned TicksPerSecondDef = 10;

  localparam int unsigned PeriodW  = 16;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [5:0] SecLast  = 6'd59;
  localparam logic [5:0] MinLast  = 6'd59;
  localparam logic [4:0] HourLast = 5'd23;
  localparam logic [2:0] WeekLast = 3'd7;
  localparam logic [2:0] WeekFirst = 3'd1;
  // notify modulus while the time is not yet set
  localparam logic [PeriodW:0] UnsetModulus = 17'd2;

  typedef enum logic [1:0] {
    ReqTick = 2'd0,
    ReqSet  = 2'd1,
    ReqRead = 2'd2
  } req_e;

  typedef enum logic {
    RegUpdatePeriod = 1'b0,
    RegNotifyEnable = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [PeriodW-1:0] update_period;
    logic               notify_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] set_sec;
    logic [5:0] set_min;
    logic [4:0] set_hour;
    logic [2:0] set_week;
  } in_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [2:0] week;
    logic       time_valid;
    logic       status;
    logic       notify;
  } res_t;

endpackage

// File: src/wtc_if.sv
// Valid/ready channel interfaces of the clock unit: request and result words.
// Depends on nothing; field widths mirror wtc_pkg.
interface wtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] set_sec;
  logic [5:0] set_min;
  logic [4:0] set_hour;
  logic [2:0] set_week;

  modport source (output valid, req_type, set_sec, set_min, set_hour, set_week,
                  input ready);
  modport sink (input valid, req_type, set_sec, set_min, set_hour, set_week,
                output ready);
endinterface

interface wtc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] sec;
  logic [5:0] min;
  logic [4:0] hour;
  logic [2:0] week;
  logic       time_valid;
  logic       status;
  logic       notify;

  modport source (output valid, sec, min, hour, week, time_valid, status, notify,
                  input ready);
  modport sink (input valid, sec, min, hour, week, time_valid, status, notify,
                output ready);
endinterface

// File: src/wtc_apb_regs.sv
// APB configuration registers of the clock unit (update period, notify enable).
// Depends on wtc_pkg.
module wtc_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [wtc_pkg::ApbDataW-1:0]  pwdata,
  output logic [wtc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output wtc_pkg::cfg_t                 cfg_o
);
  import wtc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegUpdatePeriod: cfg_d.update_period = pwdata[PeriodW-1:0];
        RegNotifyEnable: cfg_d.notify_enable = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegUpdatePeriod: prdata = {{(ApbDataW-PeriodW){1'b0}}, cfg_q.update_period};
      RegNotifyEnable: prdata = {{(ApbDataW-1){1'b0}}, cfg_q.notify_enable};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/wtc_time_core.sv
// Clock state (prescaler, h:m:s, weekday, set flag, notify counter) and
// its next-state logic for one request word. Depends on wtc_pkg.
`include "assert_macros.svh"

module wtc_time_core #(
  parameter int unsigned TICKS_PER_SECOND = wtc_pkg::TicksPerSecondDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  wtc_pkg::in_t  item_i,
  input  wtc_pkg::cfg_t cfg_i,
  output wtc_pkg::res_t res_o
);
  import wtc_pkg::*;

  localparam int unsigned PsW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [PsW:0] PsLast = (PsW+1)'(TICKS_PER_SECOND - 1);

  logic [PsW-1:0]     ps_q, ps_d;
  logic [5:0]         sec_q, sec_d;
  logic [5:0]         min_q, min_d;
  logic [4:0]         hour_q, hour_d;
  logic [2:0]         week_q, week_d;
  logic               set_q, set_d;
  logic [PeriodW-1:0] nc_q, nc_d;

  logic               sec_tick;
  logic               status;
  logic               notify;
  logic [PeriodW:0]   nc_inc;
  logic [PeriodW:0]   modulus;

  assign nc_inc = {1'b0, nc_q} + {{PeriodW{1'b0}}, 1'b1};

  always_comb begin
    ps_d     = ps_q;
    sec_d    = sec_q;
    min_d    = min_q;
    hour_d   = hour_q;
    week_d   = week_q;
    set_d    = set_q;
    nc_d     = nc_q;
    sec_tick = 1'b0;
    status   = 1'b0;
    notify   = 1'b0;
    modulus  = UnsetModulus;

    unique case (req_e'(item_i.req_type))
      ReqTick: begin
        if ({1'b0, ps_q} >= PsLast) begin
          ps_d     = '0;
          sec_tick = 1'b1;
        end else begin
          ps_d = ps_q + 1'b1;
        end
      end
      ReqSet: begin
        sec_d  = item_i.set_sec;
        min_d  = item_i.set_min;
        hour_d = item_i.set_hour;
        week_d = item_i.set_week;
        set_d  = 1'b1;
      end
      ReqRead: status = ~set_q;
      default: ;  // reserved code: no change
    endcase

    if (sec_tick) begin
      if (set_q) begin
        // carry chain; out-of-range values wrap at their last legal value
        if (sec_q >= SecLast) begin
          sec_d = '0;
          if (min_q >= MinLast) begin
            min_d = '0;
            if (hour_q >= HourLast) begin
              hour_d = '0;
              week_d = (week_q >= WeekLast) ? WeekFirst : week_q + 3'd1;
            end else begin
              hour_d = hour_q + 5'd1;
            end
          end else begin
            min_d = min_q + 6'd1;
          end
        end else begin
          sec_d = sec_q + 6'd1;
        end
        modulus = {1'b0, cfg_i.update_period};
      end
      // period of zero disables notification once set
      if (!(set_q && (cfg_i.update_period == '0))) begin
        if (nc_inc >= modulus) begin
          nc_d   = '0;
          notify = cfg_i.notify_enable;
        end else begin
          nc_d = nc_inc[PeriodW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q   <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
      week_q <= '0;
      set_q  <= 1'b0;
      nc_q   <= '0;
    end else if (step_i) begin
      ps_q   <= ps_d;
      sec_q  <= sec_d;
      min_q  <= min_d;
      hour_q <= hour_d;
      week_q <= week_d;
      set_q  <= set_d;
      nc_q   <= nc_d;
    end
  end

  always_comb begin
    res_o.sec        = sec_d;
    res_o.min        = min_d;
    res_o.hour       = hour_d;
    res_o.week       = week_d;
    res_o.time_valid = set_d;
    res_o.status     = status;
    res_o.notify     = notify;
  end

  `WTC_ASSERT(a_set_sticky, set_q |=> set_q)
  `WTC_ASSERT(a_set_loads, (step_i && (item_i.req_type == ReqSet)) |=> set_q)
  `WTC_ASSERT(a_unset_count, !set_q |-> (nc_q <= 16'd1))
  `WTC_ASSERT(a_ps_range, {1'b0, ps_q} <= PsLast)

endmodule

// File: src/weekday_time_of_day_clock_unit.sv
// Top level of the weekday time-of-day clock unit: request and result
// channels, APB configuration, input register and result register.
// Depends on wtc_pkg, wtc_if, wtc_apb_regs, wtc_time_core.
//
// Usage:
//   in_i  (sink)  : request words - timer tick, time set or time read.
//   out_o (source): one result word per request - time after the request,
//                   time_valid, read status and the periodic notify flag.
//   APB           : register 0 update_period at 0x0, register 1
//                   notify_enable at 0x4; pready is tied high, writes land
//                   on the access cycle. Write only while the unit is idle.
// Timing:
//   A request word is captured in the input register; once the result
//   register is free or being drained, the clock state updates and the
//   result word is loaded into the result register, which drives out_o.valid.
//   One word per cycle sustained while out_o.ready stays high; the limit is
//   the combinational counter cascade (prescaler, seconds, minutes, hours,
//   weekday, notify count).
// Reset: all counters, the set flag and both valid flags clear; no word held.
// Stall: a result held on out_o blocks the input register only when it is
//   full too; in_i.ready drops after two words back up.
`include "assert_macros.svh"

module weekday_time_of_day_clock_unit #(
  parameter int unsigned TICKS_PER_SECOND = wtc_pkg::TicksPerSecondDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wtc_in_if.sink                        in_i,
  wtc_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [wtc_pkg::ApbDataW-1:0]  pwdata,
  output logic [wtc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import wtc_pkg::*;

  cfg_t cfg;
  in_t  in_word;
  in_t  s1_q;
  logic s1_valid_q;
  res_t res;
  res_t out_q;
  logic out_valid_q;
  logic advance;     // word in input register moves into result register
  logic in_fire;

  wtc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // result register free, or being drained this cycle
  assign advance  = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~s1_valid_q | advance;
  assign in_fire  = in_i.valid & in_i.ready;

  always_comb begin
    in_word.req_type = in_i.req_type;
    in_word.set_sec  = in_i.set_sec;
    in_word.set_min  = in_i.set_min;
    in_word.set_hour = in_i.set_hour;
    in_word.set_week = in_i.set_week;
  end

  wtc_time_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (s1_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_word;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sec        = out_q.sec;
  assign out_o.min        = out_q.min;
  assign out_o.hour       = out_q.hour;
  assign out_o.week       = out_q.week;
  assign out_o.time_valid = out_q.time_valid;
  assign out_o.status     = out_q.status;
  assign out_o.notify     = out_q.notify;

  `WTC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!out_valid_q && !s1_valid_q))
  `WTC_ASSERT(a_block_only_full,
      !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
  `WTC_ASSERT(a_advance_loads, advance |=> out_valid_q)

endmodule

// File: bench/weekday_time_of_day_clock_unit_tb.sv
// Self-checking bench for weekday_time_of_day_clock_unit: APB register setup,
// directed and random request words, result words checked against a predictor.
// Depends on wtc_pkg, wtc_if and the unit itself.
`timescale 1ns / 100ps

module weekday_time_of_day_clock_unit_tb;
  import wtc_pkg::*;

  // request code the unit must treat as a no-op
  localparam logic [1:0] ReqReserved = 2'd3;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned WordsPerPhase = 135;
  localparam int unsigned MaxReports = 10;
  // receiver goes quiet once this many requests are in
  localparam int unsigned HoldOffAt = 500;
  localparam int unsigned HoldOffCycles = 60;

  // Tracks the clock state and queues the result word each request must give.
  class wtc_time_tracker;
    logic [PeriodW-1:0] update_period;
    logic               notify_enable;
    logic [3:0]         prescale;
    logic [5:0]         sec_q;
    logic [5:0]         min_q;
    logic [4:0]         hour_q;
    logic [2:0]         week_q;
    logic               time_set;
    logic [PeriodW-1:0] notify_count;
    res_t               expected_times[$];
    int unsigned        mismatches;
    int unsigned        accepted;

    function new();
      update_period = '0;
      notify_enable = 1'b0;
      prescale      = '0;
      sec_q         = '0;
      min_q         = '0;
      hour_q        = '0;
      week_q        = '0;
      time_set      = 1'b0;
      notify_count  = '0;
      mismatches    = 0;
      accepted      = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [ApbDataW-1:0] value);
      if (idx == RegUpdatePeriod) begin
        update_period = value[PeriodW-1:0];
      end else begin
        notify_enable = value[0];
      end
    endfunction

    // One second elapsed: carry the time, run the notify counter.
    function logic second_tick();
      logic [PeriodW:0] modulus;
      logic [PeriodW:0] nxt;
      if (time_set) begin
        if (sec_q >= SecLast) begin
          sec_q = '0;
          if (min_q >= MinLast) begin
            min_q = '0;
            if (hour_q >= HourLast) begin
              hour_q = '0;
              week_q = (week_q >= WeekLast) ? WeekFirst : week_q + 3'd1;
            end else begin
              hour_q = hour_q + 5'd1;
            end
          end else begin
            min_q = min_q + 6'd1;
          end
        end else begin
          sec_q = sec_q + 6'd1;
        end
        // period 0 freezes the counter once set
        if (update_period == '0) return 1'b0;
        modulus = {1'b0, update_period};
      end else begin
        modulus = UnsetModulus;
      end
      nxt = {1'b0, notify_count} + 1'b1;
      if (nxt >= modulus) begin
        notify_count = '0;
        return notify_enable;
      end
      notify_count = nxt[PeriodW-1:0];
      return 1'b0;
    endfunction

    function void note_request(in_t req);
      res_t        r;
      int unsigned nxt;
      r = '0;
      case (req.req_type)
        ReqTick: begin
          nxt = int'(prescale) + 1;
          if (nxt >= TicksPerSecondDef) begin
            prescale = '0;
            r.notify = second_tick();
          end else begin
            prescale = 4'(nxt);
          end
        end
        ReqSet: begin
          sec_q    = req.set_sec;
          min_q    = req.set_min;
          hour_q   = req.set_hour;
          week_q   = req.set_week;
          time_set = 1'b1;
        end
        ReqRead: r.status = !time_set;
        default: ;
      endcase
      r.sec        = sec_q;
      r.min        = min_q;
      r.hour       = hour_q;
      r.week       = week_q;
      r.time_valid = time_set;
      expected_times.push_back(r);
      accepted++;
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      bit   bad;
      if (expected_times.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result word %p", $realtime, got);
        return;
      end
      exp_r = expected_times.pop_front();
      bad = (got.sec != exp_r.sec) || (got.min != exp_r.min) ||
            (got.hour != exp_r.hour) || (got.week != exp_r.week) ||
            (got.time_valid != exp_r.time_valid) ||
            (got.status != exp_r.status) || (got.notify != exp_r.notify);
      if (bad) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result mismatch, expected %p, got %p", $realtime, exp_r, got);
      end
    endfunction

    function int unsigned pending();
      return expected_times.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  wtc_in_if  req_if ();
  wtc_out_if res_if ();

  wtc_time_tracker tracker = new();

  // words left in the current sender burst
  int unsigned burst_left = 0;

  weekday_time_of_day_clock_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  // Monitor: both channels sampled on the rising edge. The request is noted
  // first so a result given in the same cycle as its request would still find its expectation.
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      tracker.note_request('{req_type: req_if.req_type, set_sec: req_if.set_sec,
                             set_min: req_if.set_min, set_hour: req_if.set_hour,
                             set_week: req_if.set_week});
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      tracker.check_result('{sec: res_if.sec, min: res_if.min, hour: res_if.hour,
                             week: res_if.week, time_valid: res_if.time_valid,
                             status: res_if.status, notify: res_if.notify});
    end
  end

  // APB write: setup cycle, then access cycle; the register takes the value
  // on the edge where psel, penable, pwrite and pready are all high.
  task automatic apb_write(input reg_idx_e idx, input logic [ApbDataW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ApbAddrW'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Offer one request word; opens a random gap whenever a burst runs out.
  task automatic offer(input in_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk_i);
    req_if.req_type = w.req_type;
    req_if.set_sec  = w.set_sec;
    req_if.set_min  = w.set_min;
    req_if.set_hour = w.set_hour;
    req_if.set_week = w.set_week;
    req_if.valid    = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Stop offering and let every outstanding result come back, plus a margin
  // for the two-stage pipe before touching registers.
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_t make_request(logic [1:0] kind, logic [5:0] s, logic [5:0] m,
                                       logic [4:0] h, logic [2:0] wd);
    in_t w;
    w.req_type = kind;
    w.set_sec  = s;
    w.set_min  = m;
    w.set_hour = h;
    w.set_week = wd;
    return w;
  endfunction

  // Mostly ticks so seconds actually roll; sets are often parked right at the
  // wrap point so a single second carries all the way into the weekday.
  function automatic in_t random_request();
    in_t w;
    int  pick;
    w = make_request(ReqTick, 6'($urandom), 6'($urandom), 5'($urandom), 3'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      w.req_type = ReqTick;
    end else if (pick < 89) begin
      w.req_type = ReqSet;
      if ($urandom_range(0, 1) == 1) begin
        w.set_sec  = 6'($urandom_range(58, 63));
        w.set_min  = 6'($urandom_range(59, 63));
        w.set_hour = 5'($urandom_range(23, 31));
      end
    end else if (pick < 97) begin
      w.req_type = ReqRead;
    end else begin
      w.req_type = ReqReserved;
    end
    return w;
  endfunction

  // Result receiver: runs of always-ready, coin-flip, mostly-ready and
  // mostly-stalled. Once, mid-run, it holds off for a long stretch so the
  // unit backs up and drops in_i.ready while the sender keeps offering.
  initial begin : result_sink
    int unsigned mode;
    int unsigned run;
    bit          held_off;
    held_off = 1'b0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(5, 40);
      repeat (run) begin
        @(negedge clk_i);
        if (!held_off && tracker.accepted >= HoldOffAt) begin
          held_off = 1'b1;
          res_if.ready = 1'b0;
          repeat (HoldOffCycles) @(negedge clk_i);
        end
        case (mode)
          0: res_if.ready = 1'b1;
          1: res_if.ready = 1'($urandom_range(0, 1));
          2: res_if.ready = ($urandom_range(0, 3) != 0);
          default: res_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("FAIL weekday_time_of_day_clock_unit");
    $finish;
  end

  initial begin : stimulus
    logic [PeriodW-1:0] periods [PhaseCount];
    bit                 enables [PhaseCount];
    logic [PeriodW-1:0] period;
    periods = '{16'd1, 16'd2, 16'hFFFF, 16'd7, 16'd3, 16'd0, 16'd4, 16'd1};
    enables = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    req_if.valid    = 1'b0;
    req_if.req_type = ReqTick;
    req_if.set_sec  = '0;
    req_if.set_min  = '0;
    req_if.set_hour = '0;
    req_if.set_week = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening. Enable notify so the pre-set every-second-second
    // pulse is visible; period 0 is the disabled extreme.
    apb_write(RegUpdatePeriod, '0);
    apb_write(RegNotifyEnable, 32'd1);
    offer(make_request(ReqRead, '0, '0, '0, '0));        // read before set
    offer(make_request(ReqReserved, '1, '1, '1, '1));    // reserved code, no-op
    repeat (20) offer(make_request(ReqTick, '1, '1, '1, '1)); // two unset seconds
    offer(make_request(ReqSet, '1, '1, '1, '0));         // out-of-range load
    offer(make_request(ReqRead, '0, '0, '0, '0));
    offer(make_request(ReqSet, SecLast, MinLast, HourLast, WeekLast)); // full wrap
    drain();

    // Random phases, each under its own register setting. Period 7 then 3
    // and a random 4 to 12 then 1 shrink the period under a running counter.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      period = (ph == 6) ? PeriodW'($urandom_range(4, 12)) : periods[ph];
      apb_write(RegUpdatePeriod, {16'd0, period});
      apb_write(RegNotifyEnable, {31'd0, enables[ph]});
      repeat (WordsPerPhase) offer(random_request());
      drain();
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS weekday_time_of_day_clock_unit");
    end else begin
      $display("FAIL weekday_time_of_day_clock_unit");
    end
    $finish;
  end

endmodule
